// File: rtl/cpt_pkg.sv
// shared opcodes, control struct and coefficient helpers of the clarke/park transform unit
package cpt_pkg;

  // transform opcodes
  localparam logic [2:0] CMD_CLARKE3    = 3'd0;
  localparam logic [2:0] CMD_CLARKE2    = 3'd1;
  localparam logic [2:0] CMD_INV_CLARKE = 3'd2;
  localparam logic [2:0] CMD_PARK       = 3'd3;
  localparam logic [2:0] CMD_INV_PARK   = 3'd4;
  localparam logic [2:0] CMD_ABC_TO_DQ  = 3'd5;
  localparam logic [2:0] CMD_DQ_TO_ABC  = 3'd6;
  localparam logic [2:0] CMD_UNUSED     = 3'd7;

  // control that travels with each request down the pipeline
  typedef struct packed {
    logic       vld;
    logic [2:0] cmd;
    logic       pinv;
  } ctl_t;

  // round half up of m * 2^cfrac / 10^6, elaboration time only
  function automatic longint coef_q(input longint m, input int cfrac);
    return ((m << cfrac) + 64'sd500000) / 64'sd1000000;
  endfunction

  // forward clarke in the first unit
  function automatic logic op_fwd_clarke(input logic [2:0] cmd);
    return cmd inside {CMD_CLARKE3, CMD_CLARKE2, CMD_ABC_TO_DQ};
  endfunction

  // three-phase input (uses phase c)
  function automatic logic op_three_phase(input logic [2:0] cmd);
    return cmd inside {CMD_CLARKE3, CMD_ABC_TO_DQ};
  endfunction

  // any rotation
  function automatic logic op_rotate(input logic [2:0] cmd);
    return cmd inside {CMD_PARK, CMD_INV_PARK, CMD_ABC_TO_DQ, CMD_DQ_TO_ABC};
  endfunction

  // rotation by minus the angle
  function automatic logic op_inv_rotate(input logic [2:0] cmd);
    return cmd inside {CMD_INV_PARK, CMD_DQ_TO_ABC};
  endfunction

  // inverse clarke in the last unit
  function automatic logic op_inv_clarke(input logic [2:0] cmd);
    return cmd inside {CMD_INV_CLARKE, CMD_DQ_TO_ABC};
  endfunction

endpackage

// File: rtl/cpt_clarke.sv
// forward clarke stage group: pre-add, coefficient multiply, round
module cpt_clarke import cpt_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctl_t                         ctl_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic signed [DATA_WIDTH-1:0] z_i,
  input  logic signed [DATA_WIDTH-1:0] sn_i,
  input  logic signed [DATA_WIDTH-1:0] cs_i,
  output ctl_t                         ctl_o,
  output logic signed [DATA_WIDTH+1:0] v1_o,
  output logic signed [DATA_WIDTH+1:0] v2_o,
  output logic signed [DATA_WIDTH-1:0] sn_o,
  output logic signed [DATA_WIDTH-1:0] cs_o
);

  localparam int IW = DATA_WIDTH + 2;
  localparam int PW = IW + COEF_WIDTH + 1;
  localparam int CF = COEF_WIDTH - 1;

  localparam logic [COEF_WIDTH-1:0] K_ONE  = COEF_WIDTH'(1) << CF;
  localparam logic [COEF_WIDTH-1:0] K_667  = COEF_WIDTH'(coef_q(64'sd666667, CF));
  localparam logic [COEF_WIDTH-1:0] K_816  = COEF_WIDTH'(coef_q(64'sd816496, CF));
  localparam logic [COEF_WIDTH-1:0] K_577  = COEF_WIDTH'(coef_q(64'sd577350, CF));
  localparam logic [COEF_WIDTH-1:0] K_707  = COEF_WIDTH'(coef_q(64'sd707106, CF));
  localparam logic [COEF_WIDTH-1:0] K_1225 = COEF_WIDTH'(coef_q(64'sd1224744, CF));

  localparam logic signed [PW-1:0] RND_HI = PW'(1) << CF;
  localparam logic signed [PW-1:0] RND_LO = PW'(1) << (CF - 1);

  logic signed [IW-1:0] xe, ye, ze;
  logic signed [IW-1:0] m1_d, m2_d;
  logic [COEF_WIDTH-1:0] k1_d, k2_d;

  ctl_t                         ctl1_q, ctl2_q, ctl3_q;
  logic signed [IW-1:0]         m1_q, m2_q, xp1_q, yp1_q, xp2_q, yp2_q;
  logic [COEF_WIDTH-1:0]        k1_q, k2_q;
  logic signed [DATA_WIDTH-1:0] sn1_q, cs1_q, sn2_q, cs2_q, sn3_q, cs3_q;
  logic signed [COEF_WIDTH:0]   k1s, k2s;
  logic signed [PW-1:0]         p1_d, p2_d, p1_q, p2_q;
  logic signed [PW-1:0]         sum1, sum2;
  logic signed [IW-1:0]         r1, r2, v1_d, v2_d, v1_q, v2_q;

  assign xe = IW'(x_i);
  assign ye = IW'(y_i);
  assign ze = IW'(z_i);

  // operand pre-add and coefficient select; two-phase alpha doubled to share the shift
  always_comb begin
    if (op_three_phase(ctl_i.cmd)) begin
      m1_d = (xe <<< 1) - ye - ze;
      m2_d = ye - ze;
      k1_d = ctl_i.pinv ? K_816 : K_667;
    end else begin
      m1_d = xe <<< 1;
      m2_d = xe + (ye <<< 1);
      k1_d = ctl_i.pinv ? K_1225 : K_ONE;
    end
    k2_d = ctl_i.pinv ? K_707 : K_577;
  end

  // coefficient multiply
  assign k1s  = {1'b0, k1_q};
  assign k2s  = {1'b0, k2_q};
  assign p1_d = PW'(m1_q) * PW'(k1s);
  assign p2_d = PW'(m2_q) * PW'(k2s);

  // round half up; alpha carries one extra fraction bit
  assign sum1 = p1_q + RND_HI;
  assign sum2 = p2_q + RND_LO;
  assign r1   = sum1[COEF_WIDTH +: IW];
  assign r2   = sum2[CF +: IW];
  assign v1_d = op_fwd_clarke(ctl2_q.cmd) ? r1 : xp2_q;
  assign v2_d = op_fwd_clarke(ctl2_q.cmd) ? r2 : yp2_q;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // data pipeline
  always_ff @(posedge clk_i) begin
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    k1_q  <= k1_d;
    k2_q  <= k2_d;
    xp1_q <= xe;
    yp1_q <= ye;
    sn1_q <= sn_i;
    cs1_q <= cs_i;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    xp2_q <= xp1_q;
    yp2_q <= yp1_q;
    sn2_q <= sn1_q;
    cs2_q <= cs1_q;
    v1_q  <= v1_d;
    v2_q  <= v2_d;
    sn3_q <= sn2_q;
    cs3_q <= cs2_q;
  end

  assign ctl_o = ctl3_q;
  assign v1_o  = v1_q;
  assign v2_o  = v2_q;
  assign sn_o  = sn3_q;
  assign cs_o  = cs3_q;

endmodule

// File: rtl/cpt_rotate.sv
// park rotation stage group: sine select, four products, sum and round
module cpt_rotate import cpt_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctl_t                         ctl_i,
  input  logic signed [DATA_WIDTH+1:0] x_i,
  input  logic signed [DATA_WIDTH+1:0] y_i,
  input  logic signed [DATA_WIDTH-1:0] sn_i,
  input  logic signed [DATA_WIDTH-1:0] cs_i,
  output ctl_t                         ctl_o,
  output logic signed [DATA_WIDTH+1:0] v1_o,
  output logic signed [DATA_WIDTH+1:0] v2_o
);

  localparam int IW  = DATA_WIDTH + 2;
  localparam int SNW = DATA_WIDTH + 1;
  localparam int MW  = SNW + IW;
  localparam int SW  = MW + 1;
  localparam int F   = DATA_WIDTH - 1;

  localparam logic signed [SW-1:0] RND = SW'(1) << (F - 1);

  logic signed [SNW-1:0] sne, nse, sa_d, sb_d;
  logic                  inv;

  ctl_t                  ctl1_q, ctl2_q, ctl3_q;
  logic signed [SNW-1:0] cs1_q, sa1_q, sb1_q;
  logic signed [IW-1:0]  x1_q, y1_q, x2_q, y2_q;
  logic signed [MW-1:0]  pcx_d, pay_d, pbx_d, pcy_d;
  logic signed [MW-1:0]  pcx_q, pay_q, pbx_q, pcy_q;
  logic signed [SW-1:0]  sum1, sum2;
  logic signed [IW-1:0]  o1, o2, v1_d, v2_d, v1_q, v2_q;

  // sine sign per direction; negation needs one extra bit
  assign sne  = SNW'(sn_i);
  assign nse  = -sne;
  assign inv  = op_inv_rotate(ctl_i.cmd);
  assign sa_d = inv ? nse : sne;
  assign sb_d = inv ? sne : nse;

  // four products
  assign pcx_d = MW'(cs1_q) * MW'(x1_q);
  assign pay_d = MW'(sa1_q) * MW'(y1_q);
  assign pbx_d = MW'(sb1_q) * MW'(x1_q);
  assign pcy_d = MW'(cs1_q) * MW'(y1_q);

  // dot products rounded half up to data fraction bits
  assign sum1 = SW'(pcx_q) + SW'(pay_q) + RND;
  assign sum2 = SW'(pbx_q) + SW'(pcy_q) + RND;
  assign o1   = sum1[F +: IW];
  assign o2   = sum2[F +: IW];
  assign v1_d = op_rotate(ctl2_q.cmd) ? o1 : x2_q;
  assign v2_d = op_rotate(ctl2_q.cmd) ? o2 : y2_q;

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // data pipeline
  always_ff @(posedge clk_i) begin
    cs1_q <= SNW'(cs_i);
    sa1_q <= sa_d;
    sb1_q <= sb_d;
    x1_q  <= x_i;
    y1_q  <= y_i;
    pcx_q <= pcx_d;
    pay_q <= pay_d;
    pbx_q <= pbx_d;
    pcy_q <= pcy_d;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    v1_q  <= v1_d;
    v2_q  <= v2_d;
  end

  assign ctl_o = ctl3_q;
  assign v1_o  = v1_q;
  assign v2_o  = v2_q;

endmodule

// File: rtl/cpt_iclarke.sv
// inverse clarke stage group: coefficient select, multiply, combine and round
module cpt_iclarke import cpt_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctl_t                         ctl_i,
  input  logic signed [DATA_WIDTH+1:0] al_i,
  input  logic signed [DATA_WIDTH+1:0] be_i,
  output ctl_t                         ctl_o,
  output logic signed [DATA_WIDTH+1:0] r1_o,
  output logic signed [DATA_WIDTH+1:0] r2_o,
  output logic signed [DATA_WIDTH+1:0] r3_o
);

  localparam int IW = DATA_WIDTH + 2;
  localparam int PW = IW + COEF_WIDTH + 1;
  localparam int QW = PW + 2;
  localparam int CF = COEF_WIDTH - 1;

  localparam logic [COEF_WIDTH-1:0] K_ONE = COEF_WIDTH'(1) << CF;
  localparam logic [COEF_WIDTH-1:0] K_866 = COEF_WIDTH'(coef_q(64'sd866025, CF));
  localparam logic [COEF_WIDTH-1:0] K_816 = COEF_WIDTH'(coef_q(64'sd816496, CF));
  localparam logic [COEF_WIDTH-1:0] K_707 = COEF_WIDTH'(coef_q(64'sd707106, CF));

  localparam logic signed [QW-1:0] RND_HI = QW'(1) << CF;
  localparam logic signed [QW-1:0] RND_LO = QW'(1) << (CF - 1);

  ctl_t                       ctl1_q, ctl2_q, ctl3_q;
  logic [COEF_WIDTH-1:0]      ku_q, kt_q;
  logic signed [COEF_WIDTH:0] kus, kts;
  logic signed [IW-1:0]       al1_q, be1_q, al2_q, be2_q;
  logic signed [PW-1:0]       u_d, t_d, u_q, t_q;
  logic signed [QW-1:0]       ue, te2, asum, bsum, csum;
  logic signed [IW-1:0]       ra, rb, rc;
  logic signed [IW-1:0]       r1_d, r2_d, r3_d, r1_q, r2_q, r3_q;

  // u is alpha times 2/sqrt(6) or 1 (amplitude case doubled), t is beta times the cross term
  assign kus = {1'b0, ku_q};
  assign kts = {1'b0, kt_q};
  assign u_d = PW'(al1_q) * PW'(kus);
  assign t_d = PW'(be1_q) * PW'(kts);

  // a = u, b = (2t - u) / 2, c = (-u - 2t) / 2, each rounded half up
  assign ue   = QW'(u_q);
  assign te2  = QW'(t_q) <<< 1;
  assign asum = ue + RND_LO;
  assign bsum = te2 - ue + RND_HI;
  assign csum = -ue - te2 + RND_HI;
  assign ra   = asum[CF +: IW];
  assign rb   = bsum[COEF_WIDTH +: IW];
  assign rc   = csum[COEF_WIDTH +: IW];

  // third output only for inverse clarke
  always_comb begin
    if (op_inv_clarke(ctl2_q.cmd)) begin
      r1_d = ra;
      r2_d = rb;
      r3_d = rc;
    end else begin
      r1_d = al2_q;
      r2_d = be2_q;
      r3_d = '0;
    end
  end

  // control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  // data pipeline
  always_ff @(posedge clk_i) begin
    ku_q  <= ctl_i.pinv ? K_816 : K_ONE;
    kt_q  <= ctl_i.pinv ? K_707 : K_866;
    al1_q <= al_i;
    be1_q <= be_i;
    u_q   <= u_d;
    t_q   <= t_d;
    al2_q <= al1_q;
    be2_q <= be1_q;
    r1_q  <= r1_d;
    r2_q  <= r2_d;
    r3_q  <= r3_d;
  end

  assign ctl_o = ctl3_q;
  assign r1_o  = r1_q;
  assign r2_o  = r2_q;
  assign r3_o  = r3_q;

endmodule

// File: rtl/clarke_park_transform_unit.sv
// top level of the clarke/park transform unit: config register, unit chain, saturation
// Takes one request per clock: busy is never asserted, so start may be held high every
// cycle. Each result appears on out_x_o/out_y_o/out_z_o/saturated_o with done_o high for
// exactly one cycle, after three register stages each for forward clarke, rotation and
// inverse clarke and one for saturation; results come back in request order and cannot
// be held off. Every opcode passes through the whole chain, so latency is the same for
// all of them. Each multiplier sits in a stage of its own. The scaling bit is
// written through cfg_valid_i/cfg_data_i (cfg_ready_o is always high) and must be written
// while no request is in flight.
module clarke_park_transform_unit import cpt_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd_i,
  input  logic signed [DATA_WIDTH-1:0] in_x_i,
  input  logic signed [DATA_WIDTH-1:0] in_y_i,
  input  logic signed [DATA_WIDTH-1:0] in_z_i,
  input  logic signed [DATA_WIDTH-1:0] sin_val_i,
  input  logic signed [DATA_WIDTH-1:0] cos_val_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] out_x_o,
  output logic signed [DATA_WIDTH-1:0] out_y_o,
  output logic signed [DATA_WIDTH-1:0] out_z_o,
  output logic                         saturated_o
);

  localparam int IW      = DATA_WIDTH + 2;
  localparam int LATENCY = 10;

  localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic                         pinv_q;
  ctl_t                         ctl_in, ctl_c, ctl_r, ctl_i3;
  logic signed [IW-1:0]         c1, c2, rt1, rt2, ic1, ic2, ic3;
  logic signed [DATA_WIDTH-1:0] sn_c, cs_c;
  logic [DATA_WIDTH:0]          sx, sy, sz;
  logic                         done_q, sat_q;
  logic signed [DATA_WIDTH-1:0] ox_q, oy_q, oz_q;

  // clip to data range; msb of the result is the clip flag
  function automatic logic [DATA_WIDTH:0] clip(input logic signed [IW-1:0] v);
    logic ovf;
    ovf = (v[IW-1:DATA_WIDTH-1] != {(IW-DATA_WIDTH+1){v[IW-1]}});
    if (ovf) begin
      return {1'b1, (v[IW-1] ? SAT_MIN : SAT_MAX)};
    end
    return {1'b0, v[DATA_WIDTH-1:0]};
  endfunction

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // scaling mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pinv_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pinv_q <= cfg_data_i;
    end
  end

  // request control entering the chain
  assign ctl_in.vld  = start && !busy;
  assign ctl_in.cmd  = cmd_i;
  assign ctl_in.pinv = pinv_q;

  cpt_clarke #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_clarke (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_in),
    .x_i    (in_x_i),
    .y_i    (in_y_i),
    .z_i    (in_z_i),
    .sn_i   (sin_val_i),
    .cs_i   (cos_val_i),
    .ctl_o  (ctl_c),
    .v1_o   (c1),
    .v2_o   (c2),
    .sn_o   (sn_c),
    .cs_o   (cs_c)
  );

  cpt_rotate #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_c),
    .x_i    (c1),
    .y_i    (c2),
    .sn_i   (sn_c),
    .cs_i   (cs_c),
    .ctl_o  (ctl_r),
    .v1_o   (rt1),
    .v2_o   (rt2)
  );

  cpt_iclarke #(
    .DATA_WIDTH (DATA_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_iclarke (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl_r),
    .al_i   (rt1),
    .be_i   (rt2),
    .ctl_o  (ctl_i3),
    .r1_o   (ic1),
    .r2_o   (ic2),
    .r3_o   (ic3)
  );

  // saturation
  assign sx = clip(ic1);
  assign sy = clip(ic2);
  assign sz = clip(ic3);

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i3.vld;
    end
  end

  // result registers, unused opcode reads as all zero
  always_ff @(posedge clk_i) begin
    if (ctl_i3.cmd == CMD_UNUSED) begin
      ox_q  <= '0;
      oy_q  <= '0;
      oz_q  <= '0;
      sat_q <= 1'b0;
    end else begin
      ox_q  <= sx[DATA_WIDTH-1:0];
      oy_q  <= sy[DATA_WIDTH-1:0];
      oz_q  <= sz[DATA_WIDTH-1:0];
      sat_q <= sx[DATA_WIDTH] | sy[DATA_WIDTH] | sz[DATA_WIDTH];
    end
  end

  assign done_o      = done_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign saturated_o = sat_q;

`ifndef SYNTHESIS
  // every request comes back after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request did not produce a result after the pipeline latency");

  // no result without a request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching request");

  // unused opcode gives zeros and no clip
  a_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(cmd_i, LATENCY) == CMD_UNUSED) |->
      (out_x_o == '0 && out_y_o == '0 && out_z_o == '0 && !saturated_o))
    else $error("unused opcode gave a nonzero result");

  // a clip flag means some output sits on a bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (out_x_o == SAT_MAX || out_x_o == SAT_MIN || out_y_o == SAT_MAX ||
       out_y_o == SAT_MIN || out_z_o == SAT_MAX || out_z_o == SAT_MIN))
    else $error("saturation flag set with no output at a bound");
`endif

endmodule

// File: verif/tb_clarke_park_transform_unit.sv
// testbench of the clarke/park transform unit: directed table plus random requests,
// checked against a fixed-point predictor of the transforms
module tb_clarke_park_transform_unit;
  import cpt_pkg::*;

  localparam int DW = 16;
  localparam int CW = 16;
  localparam int FRAC = DW - 1;
  localparam int CFRAC = CW - 1;
  localparam int PIPE_LATENCY = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES = 6;
  localparam int REQS_PER_PHASE = 315;
  localparam int NUM_DIRECTED = 22;

  // scaling coefficients, round half up of constant * 2^CFRAC
  localparam longint K_HALF_SQRT3 = (64'sd866025 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;
  localparam longint K_TWO_THIRDS = (64'sd666667 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;
  localparam longint K_SQRT_2_3 = (64'sd816496 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;
  localparam longint K_INV_SQRT3 = (64'sd577350 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;
  localparam longint K_SQRT_3_2 = (64'sd1224744 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;
  localparam longint K_INV_SQRT2 = (64'sd707106 * (longint'(1) << CFRAC) + 64'sd500000) / 64'sd1000000;

  typedef logic signed [DW-1:0] q_t;
  typedef logic [2:0] cmd_t;

  localparam q_t Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam q_t Q_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic sat;
  } xform_out_t;

  typedef struct packed {
    cmd_t       cmd;
    q_t         x;
    q_t         y;
    q_t         z;
    q_t         sn;
    q_t         cs;
    logic       typed;
    xform_out_t res;
  } stim_row_t;

  localparam xform_out_t ALL_ZERO = '{16'sd0, 16'sd0, 16'sd0, 1'b0};

  // directed requests, run with amplitude-invariant scaling after reset
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_CLARKE3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, ALL_ZERO},
    '{CMD_UNUSED, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1, ALL_ZERO},
    '{CMD_UNUSED, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, ALL_ZERO},
    '{CMD_CLARKE3, Q_MAX, Q_MIN, Q_MIN, 16'sd0, 16'sd0, 1'b0, ALL_ZERO},
    '{CMD_CLARKE3, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_CLARKE3, 16'sd0, Q_MAX, Q_MIN, 16'sd0, 16'sd0, 1'b0, ALL_ZERO},
    '{CMD_CLARKE3, 16'sd1000, -16'sd500, -16'sd500, 16'sd3000, -16'sd7000, 1'b0, ALL_ZERO},
    '{CMD_CLARKE2, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_CLARKE2, Q_MIN, 16'sd0, Q_MAX, -16'sd1, 16'sd1, 1'b0, ALL_ZERO},
    '{CMD_INV_CLARKE, Q_MIN, 16'sd0, Q_MAX, Q_MAX, Q_MAX, 1'b1,
      '{Q_MIN, 16'sd16384, 16'sd16384, 1'b0}},
    '{CMD_INV_CLARKE, Q_MAX, Q_MAX, 16'sd0, 16'sd0, 16'sd0, 1'b0, ALL_ZERO},
    '{CMD_INV_CLARKE, 16'sd0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_PARK, Q_MIN, 16'sd0, Q_MAX, 16'sd0, Q_MIN, 1'b1,
      '{Q_MAX, 16'sd0, 16'sd0, 1'b1}},
    '{CMD_PARK, Q_MAX, Q_MIN, 16'sd0, 16'sd23170, 16'sd23170, 1'b0, ALL_ZERO},
    '{CMD_INV_PARK, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_INV_PARK, 16'sd12345, -16'sd23456, 16'sd0, Q_MIN, 16'sd0, 1'b0, ALL_ZERO},
    // chained: intermediate alpha runs past full scale but must not clip
    '{CMD_ABC_TO_DQ, Q_MAX, Q_MIN, Q_MIN, 16'sd0, 16'sd16384, 1'b0, ALL_ZERO},
    '{CMD_ABC_TO_DQ, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_DQ_TO_ABC, Q_MAX, Q_MAX, Q_MIN, 16'sd23170, 16'sd23170, 1'b0, ALL_ZERO},
    '{CMD_DQ_TO_ABC, Q_MIN, Q_MIN, 16'sd0, Q_MAX, Q_MIN, 1'b0, ALL_ZERO},
    '{CMD_PARK, 16'sd0, 16'sd0, Q_MIN, Q_MIN, Q_MIN, 1'b1, ALL_ZERO},
    '{CMD_CLARKE2, 16'sd0, 16'sd0, Q_MAX, Q_MAX, Q_MIN, 1'b1, ALL_ZERO}
  };

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  cmd_t cmd_i;
  q_t   in_x_i;
  q_t   in_y_i;
  q_t   in_z_i;
  q_t   sin_val_i;
  q_t   cos_val_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;
  logic done_o;
  q_t   out_x_o;
  q_t   out_y_o;
  q_t   out_z_o;
  logic saturated_o;

  logic       scale_pinv;
  xform_out_t pending_results[$];
  int         mismatches = 0;
  int         cycle_cnt = 0;

  clarke_park_transform_unit #(
    .DATA_WIDTH(DW),
    .COEF_WIDTH(CW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .in_x_i     (in_x_i),
    .in_y_i     (in_y_i),
    .in_z_i     (in_z_i),
    .sin_val_i  (sin_val_i),
    .cos_val_i  (cos_val_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .saturated_o(saturated_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // round half up of p / 2^n
  function automatic longint round_shift(input longint p, input int n);
    return (p + (longint'(1) << (n - 1))) >>> n;
  endfunction

  // clip to q1.15 range, flag any clipping
  function automatic q_t clip_q(input longint v, inout logic flag);
    longint hi;
    longint lo;
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      flag = 1'b1;
      return Q_MAX;
    end
    if (v < lo) begin
      flag = 1'b1;
      return Q_MIN;
    end
    return q_t'(v);
  endfunction

  // three-phase clarke into alpha/beta
  function automatic void abc_to_ab(input longint a, input longint b, input longint c,
                                    input logic pinv, output longint al, output longint be);
    al = round_shift((2 * a - b - c) * (pinv ? K_SQRT_2_3 : K_TWO_THIRDS), CFRAC + 1);
    be = round_shift((b - c) * (pinv ? K_INV_SQRT2 : K_INV_SQRT3), CFRAC);
  endfunction

  // inverse clarke from alpha/beta into three phases
  function automatic void ab_to_abc(input longint al, input longint be, input logic pinv,
                                    output longint a, output longint b, output longint c);
    longint u;
    longint t;
    if (pinv) begin
      u = al * K_SQRT_2_3;
      t = 2 * be * K_INV_SQRT2;
      a = round_shift(u, CFRAC);
      b = round_shift(t - u, CFRAC + 1);
      c = round_shift(-u - t, CFRAC + 1);
    end else begin
      u = al * (longint'(1) << (CFRAC - 1));
      t = be * K_HALF_SQRT3;
      a = al;
      b = round_shift(t - u, CFRAC);
      c = round_shift(-u - t, CFRAC);
    end
  endfunction

  // rotation by the rotor angle (park) or by minus it (inverse park)
  function automatic void rotate_pair(input longint x, input longint y, input longint sn,
                                      input longint cs, input logic inverse,
                                      output longint o1, output longint o2);
    if (inverse) begin
      o1 = round_shift(cs * x - sn * y, FRAC);
      o2 = round_shift(sn * x + cs * y, FRAC);
    end else begin
      o1 = round_shift(cs * x + sn * y, FRAC);
      o2 = round_shift(cs * y - sn * x, FRAC);
    end
  endfunction

  // expected result of one request under the current scaling
  function automatic xform_out_t transform_predict(input cmd_t cmd, input q_t x, input q_t y,
                                                   input q_t z, input q_t sn, input q_t cs,
                                                   input logic pinv);
    longint r1;
    longint r2;
    longint r3;
    longint m1;
    longint m2;
    logic flag;
    xform_out_t res;
    r1 = 0;
    r2 = 0;
    r3 = 0;
    flag = 1'b0;
    case (cmd)
      CMD_CLARKE3: abc_to_ab(x, y, z, pinv, r1, r2);
      CMD_CLARKE2: begin
        if (pinv) begin
          r1 = round_shift(longint'(x) * K_SQRT_3_2, CFRAC);
          r2 = round_shift((longint'(x) + 2 * longint'(y)) * K_INV_SQRT2, CFRAC);
        end else begin
          r1 = x;
          r2 = round_shift((longint'(x) + 2 * longint'(y)) * K_INV_SQRT3, CFRAC);
        end
      end
      CMD_INV_CLARKE: ab_to_abc(x, y, pinv, r1, r2, r3);
      CMD_PARK: rotate_pair(x, y, sn, cs, 1'b0, r1, r2);
      CMD_INV_PARK: rotate_pair(x, y, sn, cs, 1'b1, r1, r2);
      CMD_ABC_TO_DQ: begin
        abc_to_ab(x, y, z, pinv, m1, m2);
        rotate_pair(m1, m2, sn, cs, 1'b0, r1, r2);
      end
      CMD_DQ_TO_ABC: begin
        rotate_pair(x, y, sn, cs, 1'b1, m1, m2);
        ab_to_abc(m1, m2, pinv, r1, r2, r3);
      end
      default: ;
    endcase
    res.x = clip_q(r1, flag);
    res.y = clip_q(r2, flag);
    res.z = clip_q(r3, flag);
    res.sat = flag;
    return res;
  endfunction

  // operand mix: extremes, small values near zero, full-range noise
  function automatic q_t pick_operand();
    case ($urandom_range(7))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return q_t'(0);
      3: return q_t'(-1);
      4: return q_t'(int'($urandom_range(511)) - 256);
      default: return q_t'($urandom);
    endcase
  endfunction

  // send one request after a random gap, record what it must produce
  task automatic issue_request(input stim_row_t row, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= row.cmd;
    in_x_i <= row.x;
    in_y_i <= row.y;
    in_z_i <= row.z;
    sin_val_i <= row.sn;
    cos_val_i <= row.cs;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (row.typed) begin
      pending_results.push_back(row.res);
    end else begin
      pending_results.push_back(transform_predict(row.cmd, row.x, row.y, row.z, row.sn,
                                                  row.cs, scale_pinv));
    end
  endtask

  // write the scaling bit once every result in flight has come back
  task automatic write_scaling(input logic pinv);
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= pinv;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    scale_pinv = pinv;
  endtask

  // result checker
  always @(posedge clk_i) begin
    xform_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: out_x %0d out_y %0d out_z %0d",
               out_x_o, out_y_o, out_z_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_x_o !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x_o);
          mismatches++;
        end
        if (out_y_o !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y_o);
          mismatches++;
        end
        if (out_z_o !== want.z) begin
          $error("out_z: expected %0d, got %0d", want.z, out_z_o);
          mismatches++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("clarke_park_transform_unit test failed");
    $finish;
  end

  // stimulus: directed table, then random phases over scaling and sender gaps
  initial begin
    logic phase_pinv [NUM_PHASES];
    int phase_idle [NUM_PHASES];
    stim_row_t row;
    phase_pinv = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_idle = '{24, 24, 47, 47, 0, 0};
    scale_pinv = 1'b0;
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= CMD_CLARKE3;
    in_x_i <= '0;
    in_y_i <= '0;
    in_z_i <= '0;
    sin_val_i <= '0;
    cos_val_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      issue_request(DIRECTED[i], 24);
    end
    start <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_scaling(phase_pinv[p]);
      for (int i = 0; i < REQS_PER_PHASE; i++) begin
        row.cmd = cmd_t'($urandom_range(7));
        row.x = pick_operand();
        row.y = pick_operand();
        row.z = pick_operand();
        row.sn = pick_operand();
        row.cs = pick_operand();
        row.typed = 1'b0;
        row.res = ALL_ZERO;
        issue_request(row, phase_idle[p]);
      end
      start <= 1'b0;
    end

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("clarke_park_transform_unit test passed");
    end else begin
      $display("clarke_park_transform_unit test failed");
    end
    $finish;
  end

endmodule
